// ===== rtl/rss_pkg.sv =====
// Shared sizes, datapath operation codes and the command struct
// for the running sample statistics unit. No dependencies.
package rss_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COUNT_W   = 16;
	localparam int FRAC_BITS = 8;
	localparam int SUM_W     = 32;
	localparam int SUMSQ_W   = 48;
	localparam int MEAN_W    = 24;
	localparam int VAR_W     = 40;
	localparam int DEV_W     = 24;
	localparam int DVD_W     = 56;
	localparam int SQ_W      = 48;
	localparam int STEP_W    = 6;

	localparam int DIV_STEPS  = DVD_W;
	localparam int SQRT_STEPS = SQ_W / 2;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACC,
		OP_MEAN_LD,
		OP_DIV_STEP,
		OP_MEAN_DONE,
		OP_VAR_A,
		OP_VAR_B,
		OP_VAR_LD,
		OP_SQRT_LD,
		OP_SQRT_STEP,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

endpackage

// ===== rtl/rss_ctrl.sv =====
// Sequencer for the statistics unit: handshakes and step counting.
// Depends on rss_pkg; drives rss_dpath through cmd_t.
module rss_ctrl
	import rss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEAN_LD,
		S_MEAN,
		S_MEAN_DONE,
		S_VAR_A,
		S_VAR_B,
		S_VAR_LD,
		S_VAR,
		S_SQRT_LD,
		S_SQRT,
		S_FIN
	} state_t;

	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              load_out;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_out  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// decode the datapath operation for this cycle
	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:      if (in_valid) cmd.op = OP_ACC;
			S_MEAN_LD:   cmd.op = OP_MEAN_LD;
			S_MEAN:      cmd.op = OP_DIV_STEP;
			S_MEAN_DONE: cmd.op = OP_MEAN_DONE;
			S_VAR_A:     cmd.op = OP_VAR_A;
			S_VAR_B:     cmd.op = OP_VAR_B;
			S_VAR_LD:    cmd.op = OP_VAR_LD;
			S_VAR:       cmd.op = OP_DIV_STEP;
			S_SQRT_LD:   cmd.op = OP_SQRT_LD;
			S_SQRT:      cmd.op = OP_SQRT_STEP;
			S_FIN:       if (load_out) cmd.op = OP_OUT;
			default:     cmd.op = OP_NONE;
		endcase
	end

	// advance the sequence and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:      if (in_valid) state_q <= S_MEAN_LD;
				S_MEAN_LD:   begin
					state_q <= S_MEAN;
					step_q  <= '0;
				end
				S_MEAN:      begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST) state_q <= S_MEAN_DONE;
				end
				S_MEAN_DONE: state_q <= S_VAR_A;
				S_VAR_A:     state_q <= S_VAR_B;
				S_VAR_B:     state_q <= S_VAR_LD;
				S_VAR_LD:    begin
					state_q <= S_VAR;
					step_q  <= '0;
				end
				S_VAR:       begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST) state_q <= S_SQRT_LD;
				end
				S_SQRT_LD:   begin
					state_q <= S_SQRT;
					step_q  <= '0;
				end
				S_SQRT:      begin
					step_q <= step_q + 1'b1;
					if (step_q == SQRT_LAST) state_q <= S_FIN;
				end
				S_FIN:       if (load_out) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/rss_dpath.sv =====
// Datapath: accumulators, bit-serial divider, bit-pair square root
// and result registers. Depends on rss_pkg; commanded by rss_ctrl.
module rss_dpath
	import rss_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic        [COUNT_W-1:0]  sample_count,
	output logic signed [SAMPLE_W-1:0] minimum,
	output logic signed [SAMPLE_W-1:0] maximum,
	output logic signed [MEAN_W-1:0]   mean_q8,
	output logic        [VAR_W-1:0]    variance_q8,
	output logic        [DEV_W-1:0]    deviation_q8,
	output logic                       full_res
);

	localparam int M_W  = SAMPLE_W + 1;
	localparam int P1_W = M_W + SUM_W;
	localparam int P2_W = 2 * M_W;
	localparam int P3_W = P2_W + COUNT_W;
	localparam int V_W  = SUMSQ_W + 2;
	localparam int SR_W = DEV_W + 2;

	// statistics state
	logic        [COUNT_W-1:0]  count_q;
	logic signed [SAMPLE_W-1:0] min_q, max_q;
	logic        [SUM_W-1:0]    sum_q;
	logic        [SUMSQ_W-1:0]  sumsq_q;
	logic                       full_q;

	// working registers
	logic                     neg_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [COUNT_W-1:0]       rem_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic signed [M_W-1:0]    m_q;
	logic signed [P1_W-1:0]   p1_q;
	logic [P2_W-1:0]          p2_q;
	logic [P3_W-1:0]          p3_q;
	logic [VAR_W-1:0]         var_q;
	logic [SQ_W-1:0]          sq_q;
	logic [SR_W-1:0]          srem_q;
	logic [DEV_W-1:0]         root_q;

	logic signed [2*SAMPLE_W-1:0] sq_prod;
	logic [SUM_W-1:0]             mag;
	logic [COUNT_W:0]             div_trial;
	logic                         div_bit;
	logic [VAR_W-1:0]             mq;
	logic [COUNT_W-1:0]           mi;
	logic [V_W-1:0]               v_full;
	logic [SR_W+1:0]              sr_trial;
	logic [SR_W+1:0]              sr_sub;
	logic                         sr_bit;

	assign sq_prod = sample * sample;
	assign mag     = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	// one quotient bit per step
	assign div_trial = {rem_q, dvd_q[DVD_W-1]};
	assign div_bit   = (div_trial >= {1'b0, count_q});

	assign mq = dvd_q[VAR_W-1:0];
	assign mi = mq[FRAC_BITS +: COUNT_W];

	// sum of squared deviations, modular over a width that holds it exactly
	assign v_full = {2'b00, sumsq_q}
		- {p1_q[P1_W-1 -: (V_W-1)], 1'b0}
		+ V_W'(p3_q);

	// one root bit per step
	assign sr_trial = {srem_q, sq_q[SQ_W-1 -: 2]};
	assign sr_sub   = {2'b00, root_q, 2'b01};
	assign sr_bit   = (sr_trial >= sr_sub);

	// hold the running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (cmd.op == OP_ACC && count_q != COUNT_LIMIT) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_q + SUM_W'(sample);
			sumsq_q <= sumsq_q + SUMSQ_W'(unsigned'(sq_prod));
		end
	end

	// work through the sequence of operations
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACC: begin
				full_q <= (count_q == COUNT_LIMIT);
				if (count_q != COUNT_LIMIT) begin
					if (count_q == '0 || sample < min_q) min_q <= sample;
					if (count_q == '0 || sample > max_q) max_q <= sample;
				end
			end
			OP_MEAN_LD: begin
				neg_q <= sum_q[SUM_W-1];
				dvd_q <= {{(DVD_W-SUM_W-FRAC_BITS){1'b0}}, mag, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= div_bit ? COUNT_W'(div_trial - {1'b0, count_q})
				                 : div_trial[COUNT_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], div_bit};
			end
			OP_MEAN_DONE: begin
				mean_q <= neg_q ? MEAN_W'(~mq[MEAN_W-1:0] + 1'b1) : mq[MEAN_W-1:0];
				m_q    <= neg_q ? -$signed({1'b0, mi}) : $signed({1'b0, mi});
			end
			OP_VAR_A: begin
				p1_q <= m_q * $signed(sum_q);
				p2_q <= m_q * m_q;
			end
			OP_VAR_B: begin
				p3_q <= p2_q * count_q;
			end
			OP_VAR_LD: begin
				dvd_q <= {v_full[SUMSQ_W-1:0], {FRAC_BITS{1'b0}}};
				rem_q <= '0;
			end
			OP_SQRT_LD: begin
				var_q  <= mq;
				sq_q   <= {mq, {FRAC_BITS{1'b0}}};
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				srem_q <= sr_bit ? SR_W'(sr_trial - sr_sub) : SR_W'(sr_trial);
				root_q <= {root_q[DEV_W-2:0], sr_bit};
				sq_q   <= {sq_q[SQ_W-3:0], 2'b00};
			end
			OP_OUT: begin
				sample_count <= count_q;
				minimum      <= min_q;
				maximum      <= max_q;
				mean_q8      <= mean_q;
				variance_q8  <= var_q;
				deviation_q8 <= root_q;
				full_res     <= full_q;
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/running_sample_statistics_unit.sv =====
// Running sample statistics: count, min, max, mean, variance, deviation.
// Depends on rss_pkg, rss_ctrl and rss_dpath.
//
// Input channel: in_valid/in_ready with one signed 16-bit sample per beat.
// Output channel: out_valid/out_ready with one result beat per sample:
// count, minimum, maximum, and mean, variance and deviation with 8
// fraction bits. full_res marks a sample dropped because the count had
// reached 65535; the held statistics are reported for it.
// Each sample runs from acceptance to a loaded result through two
// passes of a one-bit-per-cycle 56-bit divider (mean, then variance) and
// a 24-step square root, plus load and setup states. in_ready is high only
// between samples, so a new sample is taken only once the last result is loaded.
// A finished result sits in the output register; the next sample is
// accepted while it waits. If the receiver still stalls when the next
// result is ready, the unit holds it until out_ready frees the register.
// Reset clears the count and sums and drops any pending result.
module running_sample_statistics_unit
	import rss_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic        [COUNT_W-1:0]  sample_count,
	output logic signed [SAMPLE_W-1:0] minimum,
	output logic signed [SAMPLE_W-1:0] maximum,
	output logic signed [MEAN_W-1:0]   mean_q8,
	output logic        [VAR_W-1:0]    variance_q8,
	output logic        [DEV_W-1:0]    deviation_q8,
	output logic                       full_res
);

	cmd_t cmd;

	rss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	rss_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (sample),
		.sample_count (sample_count),
		.minimum      (minimum),
		.maximum      (maximum),
		.mean_q8      (mean_q8),
		.variance_q8  (variance_q8),
		.deviation_q8 (deviation_q8),
		.full_res     (full_res)
	);

endmodule
